>>> hw/rtl/ffba_pkg.sv
package ffba_pkg;

    localparam int DESC_ENTRIES = 64;
    localparam int IDX_W = $clog2(DESC_ENTRIES);
    localparam int ALIGN_BYTES = 16;
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SH = $clog2(PAGE_BYTES);
    localparam int CUR_W = 21;
    localparam logic [31:0] MAX_REQUEST = 32'hFFFF_FFE0;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ZERO = 3'd1;
    localparam logic [2:0] ST_LARGE = 3'd2;
    localparam logic [2:0] ST_OOM = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_DOUBLE = 3'd5;
    localparam logic [2:0] ST_NULL = 3'd6;

    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_PAGE_COUNT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] request_length;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [31:0] granted_size;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FIT_SCAN,
        S_FIT_COMMIT,
        S_PAGE,
        S_USED_SCAN,
        S_DFREE_SCAN,
        S_INS_SCAN,
        S_INS_COMMIT,
        S_INS_MERGE,
        S_DONE
    } state_t;

endpackage

>>> hw/rtl/first_fit_block_allocator.sv
// channel   dir  handshake               word
// request   in   start & !busy           req (mode, request_length, block_address)
// result    out  done strobe, one cycle  rsp (status, granted_address, granted_size)
// config    in   apb psel&penable&pwrite heap_start, heap_page_count
// a word rejected at the length, table or null check goes from the check state straight to done
// each scan steps through the 64-entry tables, one registered entry read a cycle
// an allocate runs check, fit scan, then fit commit if a block fits or page if none does, then done
// a free or a page tail insert adds an insert scan, an insert commit and, if both sides merge, an insert merge
// reset clears valid bits, page cursor and the sequencer at once
// the result is shown for one cycle on done; the receiver cannot stall
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        req,
    output logic        busy,
    output logic        done,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] fbase_mem [DESC_ENTRIES];
    logic [31:0] fsize_mem [DESC_ENTRIES];
    logic [31:0] ubase_mem [DESC_ENTRIES];
    logic [31:0] usize_mem [DESC_ENTRIES];
    logic [DESC_ENTRIES-1:0] fvalid_reg, fvalid_next;
    logic [DESC_ENTRIES-1:0] uvalid_reg, uvalid_next;

    state_t state_reg, state_next;
    logic [31:0] heap_start_reg;
    logic [CUR_W-1:0] page_count_reg, cursor_reg, cursor_next;
    req_t req_reg, req_next;
    logic [IDX_W:0] cnt_reg, cnt_next;
    logic [31:0] aligned_reg, aligned_next;
    logic [IDX_W-1:0] u_reg, u_next;
    logic u_ok_reg, u_ok_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic best_ok_reg, best_ok_next;
    logic [31:0] bbase_reg, bbase_next, bsize_reg, bsize_next;
    logic [IDX_W-1:0] pred_reg, pred_next, succ_reg, succ_next;
    logic pred_ok_reg, pred_ok_next, succ_ok_reg, succ_ok_next;
    logic [31:0] pbase_reg, pbase_next, psize_reg, psize_next;
    logic [31:0] sbase_reg, sbase_next, ssize_reg, ssize_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic slot_ok_reg, slot_ok_next;
    logic [31:0] ib_reg, ib_next, is_reg, is_next;
    logic from_free_reg, from_free_next;
    logic [CUR_W-1:0] pages_reg, pages_next;
    logic [31:0] gbase_reg, gbase_next;
    rsp_t rsp_reg, rsp_next;
    logic done_reg, done_next;
    logic [31:0] rd_fb_reg, rd_fs_reg, rd_ub_reg, rd_us_reg;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rd_idx;
    logic fw_en;
    logic [IDX_W-1:0] fw_idx;
    logic [31:0] fw_b, fw_s;
    logic uw_en;
    logic [32:0] len_rnd;
    logic [32:0] sum_pc;
    logic mnext, mprev;
    logic [CUR_W:0] cur_sum;

    assign idx = cnt_reg[IDX_W-1:0];
    assign rd_idx = cnt_next[IDX_W-1:0];

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp = rsp_reg;
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            REG_HEAP_START: prdata = heap_start_reg;
            default:        prdata = {{(32-CUR_W){1'b0}}, page_count_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            page_count_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_HEAP_START: heap_start_reg <= pwdata;
                default:        page_count_reg <= pwdata[CUR_W-1:0];
            endcase
        end
    end

    // table entry for the next scan step is read in the cycle before its use, addressed by cnt_next
    always_ff @(posedge clk)
    begin
        rd_fb_reg <= fbase_mem[rd_idx];
        rd_fs_reg <= fsize_mem[rd_idx];
        rd_ub_reg <= ubase_mem[rd_idx];
        rd_us_reg <= usize_mem[rd_idx];
        if (fw_en)
        begin
            fbase_mem[fw_idx] <= fw_b;
            fsize_mem[fw_idx] <= fw_s;
        end
        if (uw_en)
        begin
            ubase_mem[u_reg] <= gbase_reg;
            usize_mem[u_reg] <= aligned_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fvalid_reg <= '0;
            uvalid_reg <= '0;
            cursor_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fvalid_reg <= fvalid_next;
            uvalid_reg <= uvalid_next;
            cursor_reg <= cursor_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        cnt_reg <= cnt_next;
        aligned_reg <= aligned_next;
        u_reg <= u_next;
        u_ok_reg <= u_ok_next;
        best_reg <= best_next;
        best_ok_reg <= best_ok_next;
        bbase_reg <= bbase_next;
        bsize_reg <= bsize_next;
        pred_reg <= pred_next;
        succ_reg <= succ_next;
        pred_ok_reg <= pred_ok_next;
        succ_ok_reg <= succ_ok_next;
        pbase_reg <= pbase_next;
        psize_reg <= psize_next;
        sbase_reg <= sbase_next;
        ssize_reg <= ssize_next;
        slot_reg <= slot_next;
        slot_ok_reg <= slot_ok_next;
        ib_reg <= ib_next;
        is_reg <= is_next;
        from_free_reg <= from_free_next;
        pages_reg <= pages_next;
        gbase_reg <= gbase_next;
        rsp_reg <= rsp_next;
    end

    assign len_rnd = {1'b0, req_reg.request_length} + 33'(ALIGN_BYTES - 1);
    assign sum_pc = {1'b0, pbase_reg} + {1'b0, psize_reg};
    assign mnext = succ_ok_reg && ((ib_reg + is_reg) == sbase_reg);
    assign mprev = pred_ok_reg && (sum_pc[31:0] == ib_reg);
    assign cur_sum = {1'b0, cursor_reg} + {1'b0, pages_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (start) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!req_reg.mode)
                begin
                    if (req_reg.request_length > MAX_REQUEST || len_rnd[32]
                        || len_rnd[31:ALIGN_SH] == '0 || !u_ok_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_FIT_SCAN;
                end
                else if (req_reg.block_address == '0)
                    state_next = S_DONE;
                else
                    state_next = S_USED_SCAN;
            end
            S_FIT_SCAN:   if (cnt_reg[IDX_W]) state_next = best_ok_reg ? S_FIT_COMMIT : S_PAGE;
            S_FIT_COMMIT: state_next = S_DONE;
            S_PAGE:
            begin
                if (cur_sum > {1'b0, page_count_reg})
                    state_next = S_DONE;
                else if ({pages_reg[31-PAGE_SH:0], {PAGE_SH{1'b0}}} == aligned_reg)
                    state_next = S_DONE;
                else
                    state_next = S_INS_SCAN;
            end
            S_USED_SCAN:
            begin
                if (!cnt_reg[IDX_W] && uvalid_reg[idx] && rd_ub_reg == req_reg.block_address)
                    state_next = S_INS_SCAN;
                else if (cnt_reg[IDX_W])
                    state_next = S_DFREE_SCAN;
            end
            S_DFREE_SCAN: if (cnt_reg[IDX_W]) state_next = S_DONE;
            S_INS_SCAN:   if (cnt_reg[IDX_W]) state_next = S_INS_COMMIT;
            S_INS_COMMIT: state_next = (mprev && mnext) ? S_INS_MERGE : S_DONE;
            S_INS_MERGE:  state_next = S_DONE;
            S_DONE:       state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next = req_reg;
        cnt_next = cnt_reg;
        aligned_next = aligned_reg;
        u_next = u_reg;
        u_ok_next = u_ok_reg;
        best_next = best_reg;
        best_ok_next = best_ok_reg;
        bbase_next = bbase_reg;
        bsize_next = bsize_reg;
        pred_next = pred_reg;
        succ_next = succ_reg;
        pred_ok_next = pred_ok_reg;
        succ_ok_next = succ_ok_reg;
        pbase_next = pbase_reg;
        psize_next = psize_reg;
        sbase_next = sbase_reg;
        ssize_next = ssize_reg;
        slot_next = slot_reg;
        slot_ok_next = slot_ok_reg;
        ib_next = ib_reg;
        is_next = is_reg;
        from_free_next = from_free_reg;
        pages_next = pages_reg;
        gbase_next = gbase_reg;
        rsp_next = rsp_reg;
        done_next = 1'b0;
        fvalid_next = fvalid_reg;
        uvalid_next = uvalid_reg;
        cursor_next = cursor_reg;
        fw_en = 1'b0;
        fw_idx = idx;
        fw_b = '0;
        fw_s = '0;
        uw_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '{status: ST_OK, granted_address: '0, granted_size: '0};
                    u_ok_next = 1'b0;
                    u_next = '0;
                    for (int i = DESC_ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!uvalid_reg[i])
                        begin
                            u_ok_next = 1'b1;
                            u_next = IDX_W'(i);
                        end
                    end
                end
            end
            S_CHECK:
            begin
                aligned_next = {len_rnd[31:ALIGN_SH], {ALIGN_SH{1'b0}}};
                cnt_next = '0;
                best_ok_next = 1'b0;
                if (!req_reg.mode)
                begin
                    if (req_reg.request_length > MAX_REQUEST || len_rnd[32])
                        rsp_next.status = ST_LARGE;
                    else if (len_rnd[31:ALIGN_SH] == '0)
                        rsp_next.status = ST_ZERO;
                    else if (!u_ok_reg)
                        rsp_next.status = ST_OOM;
                end
                else if (req_reg.block_address == '0)
                    rsp_next.status = ST_NULL;
            end
            S_FIT_SCAN:
            begin
                if (!cnt_reg[IDX_W])
                begin
                    if (fvalid_reg[idx] && rd_fs_reg >= aligned_reg
                        && (!best_ok_reg || rd_fb_reg < bbase_reg))
                    begin
                        best_ok_next = 1'b1;
                        best_next = idx;
                        bbase_next = rd_fb_reg;
                        bsize_next = rd_fs_reg;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    pages_next = CUR_W'(({1'b0, aligned_reg} + 33'(PAGE_BYTES - 1)) >> PAGE_SH);
                end
            end
            S_FIT_COMMIT:
            begin
                gbase_next = bbase_reg;
                if (bsize_reg == aligned_reg)
                    fvalid_next[best_reg] = 1'b0;
                else
                begin
                    fw_en = 1'b1;
                    fw_idx = best_reg;
                    fw_b = bbase_reg + aligned_reg;
                    fw_s = bsize_reg - aligned_reg;
                end
            end
            S_PAGE:
            begin
                gbase_next = heap_start_reg + {cursor_reg[31-PAGE_SH:0], {PAGE_SH{1'b0}}};
                ib_next = heap_start_reg + {cursor_reg[31-PAGE_SH:0], {PAGE_SH{1'b0}}}
                          + aligned_reg;
                is_next = {pages_reg[31-PAGE_SH:0], {PAGE_SH{1'b0}}} - aligned_reg;
                from_free_next = 1'b0;
                cnt_next = '0;
                pred_ok_next = 1'b0;
                succ_ok_next = 1'b0;
                slot_ok_next = 1'b0;
                if (cur_sum > {1'b0, page_count_reg})
                    rsp_next.status = ST_OOM;
                else if ({pages_reg[31-PAGE_SH:0], {PAGE_SH{1'b0}}} == aligned_reg)
                    cursor_next = cur_sum[CUR_W-1:0];
            end
            S_USED_SCAN:
            begin
                if (!cnt_reg[IDX_W])
                begin
                    if (uvalid_reg[idx] && rd_ub_reg == req_reg.block_address)
                    begin
                        u_next = idx;
                        ib_next = req_reg.block_address;
                        is_next = rd_us_reg;
                        from_free_next = 1'b1;
                        cnt_next = '0;
                        pred_ok_next = 1'b0;
                        succ_ok_next = 1'b0;
                        slot_ok_next = 1'b0;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            S_DFREE_SCAN:
            begin
                if (!cnt_reg[IDX_W])
                begin
                    if (fvalid_reg[idx] && rd_fb_reg == req_reg.block_address)
                        rsp_next.status = ST_DOUBLE;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_INS_SCAN:
            begin
                if (!cnt_reg[IDX_W])
                begin
                    if (fvalid_reg[idx])
                    begin
                        if (rd_fb_reg <= ib_reg)
                        begin
                            if (!pred_ok_reg || rd_fb_reg > pbase_reg)
                            begin
                                pred_ok_next = 1'b1;
                                pred_next = idx;
                                pbase_next = rd_fb_reg;
                                psize_next = rd_fs_reg;
                            end
                        end
                        else if (!succ_ok_reg || rd_fb_reg < sbase_reg)
                        begin
                            succ_ok_next = 1'b1;
                            succ_next = idx;
                            sbase_next = rd_fb_reg;
                            ssize_next = rd_fs_reg;
                        end
                    end
                    else if (!slot_ok_reg)
                    begin
                        slot_ok_next = 1'b1;
                        slot_next = idx;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_INS_COMMIT:
            begin
                if (!mprev && !mnext && !slot_ok_reg)
                    rsp_next.status = ST_OOM;
                else
                begin
                    if (mprev)
                    begin
                        fw_en = 1'b1;
                        fw_idx = pred_reg;
                        fw_b = pbase_reg;
                        fw_s = psize_reg + is_reg;
                        psize_next = psize_reg + is_reg;
                    end
                    else if (mnext)
                    begin
                        fw_en = 1'b1;
                        fw_idx = succ_reg;
                        fw_b = ib_reg;
                        fw_s = ssize_reg + is_reg;
                    end
                    else
                    begin
                        fw_en = 1'b1;
                        fw_idx = slot_reg;
                        fw_b = ib_reg;
                        fw_s = is_reg;
                        fvalid_next[slot_reg] = 1'b1;
                    end
                    if (from_free_reg)
                        uvalid_next[u_reg] = 1'b0;
                    else
                        cursor_next = cur_sum[CUR_W-1:0];
                end
            end
            S_INS_MERGE:
            begin
                fw_en = 1'b1;
                fw_idx = pred_reg;
                fw_b = pbase_reg;
                fw_s = psize_reg + ssize_reg;
                fvalid_next[succ_reg] = 1'b0;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                if (rsp_reg.status == ST_OK)
                begin
                    if (req_reg.mode)
                        rsp_next.granted_size = is_reg;
                    else
                    begin
                        uw_en = 1'b1;
                        uvalid_next[u_reg] = 1'b1;
                        rsp_next.granted_address = gbase_reg;
                        rsp_next.granted_size = aligned_reg;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != ST_OK |-> rsp.granted_size == '0 && rsp.granted_address == '0)
        else $error("failed result carries data");
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg != $past(cursor_reg) |-> cursor_reg > $past(cursor_reg))
        else $error("page cursor moved backwards");
`endif

endmodule

>>> bench/ffba_grant_checker.sv
module ffba_grant_checker
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_t        req,
    input  logic        done,
    input  rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          outstanding
);

    localparam logic [2:0] HEAP_START_ADDR = {REG_HEAP_START, 2'b00};
    localparam logic [2:0] PAGE_COUNT_ADDR = {REG_PAGE_COUNT, 2'b00};

    logic [31:0]      heap_base;
    logic [CUR_W-1:0] heap_pages;
    logic [CUR_W-1:0] pages_taken;
    logic [31:0]      free_base [DESC_ENTRIES];
    logic [31:0]      free_size [DESC_ENTRIES];
    logic             free_vld  [DESC_ENTRIES];
    logic [31:0]      used_base [DESC_ENTRIES];
    logic [31:0]      used_size [DESC_ENTRIES];
    logic             used_vld  [DESC_ENTRIES];
    rsp_t             expected_grants [$];

    function automatic int first_free_slot();
        for (int i = 0; i < DESC_ENTRIES; i++)
            if (!free_vld[i])
                return i;
        return -1;
    endfunction

    function automatic int first_used_slot();
        for (int i = 0; i < DESC_ENTRIES; i++)
            if (!used_vld[i])
                return i;
        return -1;
    endfunction

    // returns whether the block can go back to the free table; merges on commit
    function automatic bit put_free_block(logic [31:0] b, logic [31:0] s, bit commit);
        int  below;
        int  above;
        int  slot;
        bit  join_below;
        bit  join_above;
        below = -1;
        above = -1;
        for (int i = 0; i < DESC_ENTRIES; i++) begin
            if (!free_vld[i])
                continue;
            if (free_base[i] <= b) begin
                if (below < 0 || free_base[i] > free_base[below])
                    below = i;
            end
            else begin
                if (above < 0 || free_base[i] < free_base[above])
                    above = i;
            end
        end
        join_above = above >= 0 && (b + s) == free_base[above];
        join_below = below >= 0 && (free_base[below] + free_size[below]) == b;
        if (join_below) begin
            if (commit) begin
                free_size[below] += s;
                if (join_above) begin
                    free_size[below] += free_size[above];
                    free_vld[above] = 1'b0;
                end
            end
            return 1'b1;
        end
        if (join_above) begin
            if (commit) begin
                free_base[above] = b;
                free_size[above] += s;
            end
            return 1'b1;
        end
        slot = first_free_slot();
        if (slot < 0)
            return 1'b0;
        if (commit) begin
            free_base[slot] = b;
            free_size[slot] = s;
            free_vld[slot] = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic rsp_t alloc_block(logic [31:0] len);
        rsp_t        r;
        logic [63:0] aligned64;
        logic [63:0] pages;
        logic [31:0] aligned;
        logic [31:0] base;
        logic [31:0] tail;
        int          u;
        int          f;
        r = '0;
        f = -1;
        if (len > MAX_REQUEST) begin
            r.status = ST_LARGE;
            return r;
        end
        aligned64 = ((64'(len) + ALIGN_BYTES - 1) >> ALIGN_SH) << ALIGN_SH;
        if (aligned64 > 64'hFFFF_FFFF) begin
            r.status = ST_LARGE;
            return r;
        end
        aligned = aligned64[31:0];
        if (aligned == 0) begin
            r.status = ST_ZERO;
            return r;
        end
        u = first_used_slot();
        if (u < 0) begin
            r.status = ST_OOM;
            return r;
        end
        for (int i = 0; i < DESC_ENTRIES; i++)
            if (free_vld[i] && free_size[i] >= aligned &&
                (f < 0 || free_base[i] < free_base[f]))
                f = i;
        if (f >= 0) begin
            base = free_base[f];
            if (free_size[f] == aligned)
                free_vld[f] = 1'b0;
            else begin
                free_base[f] = base + aligned;
                free_size[f] -= aligned;
            end
        end
        else begin
            pages = (aligned64 + PAGE_BYTES - 1) >> PAGE_SH;
            if (64'(pages_taken) + pages > 64'(heap_pages)) begin
                r.status = ST_OOM;
                return r;
            end
            base = heap_base + (32'(pages_taken) << PAGE_SH);
            tail = 32'(pages << PAGE_SH) - aligned;
            if (tail != 0 && !put_free_block(base + aligned, tail, 1'b0)) begin
                r.status = ST_OOM;
                return r;
            end
            pages_taken = pages_taken + CUR_W'(pages);
            if (tail != 0)
                void'(put_free_block(base + aligned, tail, 1'b1));
        end
        used_base[u] = base;
        used_size[u] = aligned;
        used_vld[u] = 1'b1;
        r.status = ST_OK;
        r.granted_address = base;
        r.granted_size = aligned;
        return r;
    endfunction

    function automatic rsp_t release_block(logic [31:0] a);
        rsp_t r;
        r = '0;
        if (a == 0) begin
            r.status = ST_NULL;
            return r;
        end
        for (int i = 0; i < DESC_ENTRIES; i++) begin
            if (used_vld[i] && used_base[i] == a) begin
                if (!put_free_block(a, used_size[i], 1'b0)) begin
                    r.status = ST_OOM;
                    return r;
                end
                void'(put_free_block(a, used_size[i], 1'b1));
                used_vld[i] = 1'b0;
                r.status = ST_OK;
                r.granted_size = used_size[i];
                return r;
            end
        end
        for (int i = 0; i < DESC_ENTRIES; i++)
            if (free_vld[i] && free_base[i] == a) begin
                r.status = ST_DOUBLE;
                return r;
            end
        r.status = ST_NOTFOUND;
        return r;
    endfunction

    function automatic rsp_t predict_grant(req_t r);
        if (r.mode == 1'b0)
            return alloc_block(r.request_length);
        return release_block(r.block_address);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        int   errs;
        errs = 0;
        if (!rst_n) begin
            heap_base = '0;
            heap_pages = '0;
            pages_taken = '0;
            for (int i = 0; i < DESC_ENTRIES; i++) begin
                free_vld[i] = 1'b0;
                used_vld[i] = 1'b0;
            end
            expected_grants.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else begin
            if (done) begin
                if (expected_grants.size() == 0) begin
                    $error("result word with no request pending");
                    errs++;
                end
                else begin
                    want = expected_grants.pop_front();
                    if (rsp.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, rsp.status);
                        errs++;
                    end
                    if (rsp.granted_address !== want.granted_address) begin
                        $error("granted_address expected %h got %h",
                               want.granted_address, rsp.granted_address);
                        errs++;
                    end
                    if (rsp.granted_size !== want.granted_size) begin
                        $error("granted_size expected %h got %h",
                               want.granted_size, rsp.granted_size);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                expected_grants.push_back(predict_grant(req));
            if (psel && penable && pwrite && pready) begin
                if (paddr == HEAP_START_ADDR)
                    heap_base = pwdata;
                else if (paddr == PAGE_COUNT_ADDR)
                    heap_pages = pwdata[CUR_W-1:0];
            end
            fail_count <= fail_count + errs;
            outstanding <= expected_grants.size();
        end
    end

endmodule

>>> bench/tb_first_fit_block_allocator.sv
module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam logic [2:0] HEAP_START_ADDR = {REG_HEAP_START, 2'b00};
    localparam logic [2:0] PAGE_COUNT_ADDR = {REG_PAGE_COUNT, 2'b00};
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 250;
    localparam int PHASE_ITEMS = 470;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        start;
    req_t        req;
    logic        busy;
    logic        done;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    int          idle_pct;
    int          stall_cycles;
    logic [31:0] live_blocks [$];
    logic [31:0] freed_blocks [$];

    first_fit_block_allocator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ffba_grant_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (done && rsp.status == ST_OK && rsp.granted_address != 0)
            live_blocks.push_back(rsp.granted_address);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic issue(req_t word);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        req <= word;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        start <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] pages);
        settle();
        write_reg(HEAP_START_ADDR, base);
        write_reg(PAGE_COUNT_ADDR, pages);
    endtask

    function automatic req_t alloc_word(logic [31:0] len);
        req_t w;
        w.mode = MODE_ALLOC;
        w.request_length = len;
        w.block_address = $urandom;
        return w;
    endfunction

    function automatic req_t free_word(logic [31:0] addr);
        req_t w;
        w.mode = MODE_FREE;
        w.request_length = $urandom;
        w.block_address = addr;
        return w;
    endfunction

    function automatic logic [31:0] take_live();
        int          k;
        logic [31:0] a;
        if (live_blocks.size() == 0)
            return $urandom;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        freed_blocks.push_back(a);
        return a;
    endfunction

    function automatic req_t random_word();
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 55)
        begin
            if (pick < 70)
                return alloc_word($urandom_range(1, 256));
            else if (pick < 85)
                return alloc_word($urandom_range(1, 8192));
            else if (pick < 90)
                return alloc_word(0);
            else if (pick < 95)
                return alloc_word($urandom);
            return alloc_word(32'hFFFF_FF00 | $urandom_range(255));
        end
        if (pick < 70)
            return free_word(take_live());
        else if (pick < 80 && freed_blocks.size() != 0)
            return free_word(freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
        else if (pick < 90)
            return free_word(0);
        return free_word($urandom);
    endfunction

    task automatic random_phase(int first_item);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if (first_item + n < 630)
                idle_pct = 34;
            else if (first_item + n < 1260)
                idle_pct = 59;
            else
                idle_pct = 0;
            issue(random_word());
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        idle_pct = 34;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_heap(32'h4000_0000, 8);
        issue(alloc_word(0));
        issue(alloc_word(32'hFFFF_FFFF));
        issue(alloc_word(32'hFFFF_FFE1));
        issue(alloc_word(32'hFFFF_FFE0));
        issue(alloc_word(1));
        issue(alloc_word(16));
        issue(alloc_word(17));
        issue(alloc_word(4080));
        issue(alloc_word(4096));
        issue(alloc_word(8000));
        issue(alloc_word(40000));
        issue(free_word(0));
        issue(free_word(32'hFFFF_FFFF));
        settle();
        issue(free_word(take_live()));
        issue(free_word(freed_blocks[0]));
        issue(free_word(take_live()));
        issue(free_word(take_live()));
        issue(free_word(take_live()));
        issue(alloc_word(48));
        issue(free_word(32'h4000_0010));
        random_phase(20);

        set_heap(32'h0000_0000, 0);
        random_phase(20 + PHASE_ITEMS);

        set_heap(32'hFFFF_F000, 32'd1048576);
        random_phase(20 + 2 * PHASE_ITEMS);

        set_heap($urandom & 32'hFFFF_F000, $urandom_range(16, 512));
        random_phase(20 + 3 * PHASE_ITEMS);

        settle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
